// ===== rtl/pidl_pkg.sv =====
// Package for the positional insert/delete list.
// Holds command and status codes and the per-cycle cell control struct.
// No dependencies.
package pidl_pkg;

   localparam int VALUE_W    = 32;
   localparam int POSITION_W = 7;
   localparam int COUNT_W    = 7;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_READ   = 2'd2
   } command_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_BADPOS = 2'd3
   } status_type;

   // Control broadcast from the top level to every cell
   typedef struct packed {
      logic shift_up;    // insert: open a gap at the position
      logic shift_down;  // delete: close the gap at the position
      logic read;        // read: drive the entry at the position on the read chain
   } cell_ctrl_type;

endpackage

// ===== rtl/pidl_cell.sv =====
// One storage cell of the positional insert/delete list.
// Holds a single entry and trades it with its neighbors; uses pidl_pkg.
module pidl_cell #(
   parameter int CMP_W = 7,
   parameter int IDX   = 0
) (
   input  logic                                  clock,
   input  pidl_pkg::cell_ctrl_type               ctrl,
   input  logic [CMP_W-1:0]                      pos,
   input  logic signed [pidl_pkg::VALUE_W-1:0]   ins_value,
   input  logic signed [pidl_pkg::VALUE_W-1:0]   prev_data,
   input  logic signed [pidl_pkg::VALUE_W-1:0]   next_data,
   input  logic signed [pidl_pkg::VALUE_W-1:0]   rd_in,
   output logic signed [pidl_pkg::VALUE_W-1:0]   rd_out,
   output logic signed [pidl_pkg::VALUE_W-1:0]   data
);
   import pidl_pkg::*;

   localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(IDX);

   logic signed [VALUE_W-1:0] data_ff, data_in;
   logic                      at_pos;
   logic                      above_pos;

   assign at_pos    = (pos == MY_IDX);
   assign above_pos = (pos < MY_IDX);

   // Pick the next entry: take from below on insert, from above on delete
   always_comb begin
      data_in = data_ff;
      if (ctrl.shift_up) begin
         if (above_pos) begin
            data_in = prev_data;
         end else if (at_pos) begin
            data_in = ins_value;
         end
      end else if (ctrl.shift_down) begin
         if (at_pos || above_pos) begin
            data_in = next_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   // Merge this entry onto the read chain when it is the one addressed
   assign rd_out = (ctrl.read && at_pos) ? (rd_in | data_ff) : rd_in;
   assign data   = data_ff;

endmodule

// ===== rtl/positional_insert_delete_list.sv =====
// Positional insert/delete list: a row of DEPTH cells, one entry each, holding an ordered list
// of signed 32-bit values. Every command (insert, delete, read) is accepted when req_valid and
// req_ready are high, and its single result is in the output register on the next cycle. A new
// command is accepted in the same cycle the previous result is taken, so the block sustains one
// transaction per cycle while results are taken; the limit is the parallel shift of the cell
// row. Entries past the count hold undefined data and are never read; no clearing pass runs
// after reset. Uses pidl_pkg and pidl_cell.
module positional_insert_delete_list #(
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [1:0]                             req_command,
   input  logic [pidl_pkg::POSITION_W-1:0]        req_position,
   input  logic signed [pidl_pkg::VALUE_W-1:0]    req_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [1:0]                             rsp_status,
   output logic [pidl_pkg::COUNT_W-1:0]           rsp_count,
   output logic signed [pidl_pkg::VALUE_W-1:0]    rsp_read_value
);
   import pidl_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > POSITION_W) ? CNT_W : POSITION_W;

   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   status_type                rsp_status_ff, status_in;
   logic [COUNT_W-1:0]        rsp_count_ff;
   logic signed [VALUE_W-1:0] rsp_read_value_ff;

   logic                      accept;
   logic [CMP_W-1:0]          count_ext, pos_ext, count_next_ext;
   logic                      full, empty, pos_le, pos_lt;
   cell_ctrl_type             ctrl;

   logic signed [VALUE_W-1:0] cell_data [DEPTH];
   logic signed [VALUE_W-1:0] rd_chain  [DEPTH+1];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign count_ext = CMP_W'(count_ff);
   assign pos_ext   = CMP_W'(req_position);
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign pos_le    = (pos_ext <= count_ext);
   assign pos_lt    = (pos_ext < count_ext);

   // Decode the command into a status, a new count and cell control
   always_comb begin
      status_in = ST_BADPOS;
      count_in  = count_ff;
      ctrl      = '0;
      unique case (req_command)
         CMD_INSERT: begin
            if (full) begin
               status_in = ST_FULL;
            end else if (pos_le) begin
               status_in     = ST_OK;
               count_in      = count_ff + CNT_W'(1);
               ctrl.shift_up = accept;
            end
         end
         CMD_DELETE: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else if (pos_lt) begin
               status_in       = ST_OK;
               count_in        = count_ff - CNT_W'(1);
               ctrl.shift_down = accept;
            end
         end
         CMD_READ: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else if (pos_lt) begin
               status_in = ST_OK;
               ctrl.read = accept;
            end
         end
         default: begin
            status_in = ST_BADPOS;
         end
      endcase
   end

   assign count_next_ext = CMP_W'(count_in);

   // Row of cells, each trading entries with its neighbors
   assign rd_chain[0] = '0;
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [VALUE_W-1:0] prev_d, next_d;
      if (i == 0) begin : g_first
         assign prev_d = '0;
      end else begin : g_prev
         assign prev_d = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign next_d = '0;
      end else begin : g_next
         assign next_d = cell_data[i+1];
      end
      pidl_cell #(
         .CMP_W (CMP_W),
         .IDX   (i)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .pos       (pos_ext),
         .ins_value (req_value),
         .prev_data (prev_d),
         .next_data (next_d),
         .rd_in     (rd_chain[i]),
         .rd_out    (rd_chain[i+1]),
         .data      (cell_data[i])
      );
   end

   // Hold the result until taken; load a new one on each accepted transaction
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff     <= status_in;
         rsp_count_ff      <= count_next_ext[COUNT_W-1:0];
         rsp_read_value_ff <= rd_chain[DEPTH];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_read_value = rsp_read_value_ff;

endmodule

// ===== rtl/pidl_checker.sv =====
// Port-level checker for the positional insert/delete list, with its bind.
// Uses pidl_pkg; attaches to positional_insert_delete_list.
module pidl_checker #(
   parameter int DEPTH = 64
) (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic [1:0]                           req_command,
   input logic [pidl_pkg::POSITION_W-1:0]      req_position,
   input logic signed [pidl_pkg::VALUE_W-1:0]  req_value,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic [1:0]                           rsp_status,
   input logic [pidl_pkg::COUNT_W-1:0]         rsp_count,
   input logic signed [pidl_pkg::VALUE_W-1:0]  rsp_read_value
);
   import pidl_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int EXT_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
   localparam logic [EXT_W-1:0] DEPTH_EXT = EXT_W'(DEPTH);

   // A pending result stays until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_count) && $stable(rsp_status))
      else $error("result changed while stalled");

   // A result follows every accepted transaction on the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("no result after accepted transaction");

   // Only a successful read carries a nonzero value
   a_rd_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> rsp_read_value == '0)
      else $error("nonzero read value on refused command");

   // Empty reports a zero count, full reports the depth
   a_empty_cnt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_EMPTY) |-> rsp_count == '0)
      else $error("empty status with nonzero count");

   a_full_cnt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL) |-> rsp_count == DEPTH_EXT[COUNT_W-1:0])
      else $error("full status with count other than depth");

endmodule

bind positional_insert_delete_list pidl_checker #(.DEPTH(DEPTH)) u_pidl_checker (.*);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the positional insert/delete list.
// Drives insert, delete and read transactions and checks every response against a list model.
// Depends on pidl_pkg and positional_insert_delete_list.
module testbench;
   import pidl_pkg::*;

   localparam int DEPTH       = 64;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_ITEMS = 300;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef struct {
      logic [1:0]                   command;
      logic [POSITION_W-1:0]        position;
      logic signed [VALUE_W-1:0]    value;
   } list_command_type;

   typedef struct {
      status_type                   status;
      logic [COUNT_W-1:0]           count;
      logic signed [VALUE_W-1:0]    read_value;
   } list_result_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic [1:0]                      req_command = CMD_READ;
   logic [POSITION_W-1:0]           req_position = '0;
   logic signed [VALUE_W-1:0]       req_value = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [1:0]                      rsp_status;
   logic [COUNT_W-1:0]              rsp_count;
   logic signed [VALUE_W-1:0]       rsp_read_value;

   list_command_type                pending_commands[$];
   list_result_type                 expected_results[$];
   list_command_type                offered_command;

   // List model and its bookkeeping
   logic signed [VALUE_W-1:0]       model_entries[DEPTH];
   int                              model_count = 0;
   int                              peak_count = 0;
   int                              plan_count = 0;

   int                              send_idle_pct = 0;
   int                              recv_stall_pct = 0;
   bit                              pressure_go = 1'b0;
   logic                            hold_off = 1'b0;
   bit                              fill_mode = 1'b0;
   int                              stretch_left = 0;

   int                              error_count = 0;
   int                              commands_queued = 0;
   int                              commands_accepted = 0;
   int                              results_checked = 0;
   int                              cycle_count = 0;
   int                              status_seen[4] = '{0, 0, 0, 0};

   positional_insert_delete_list #(
      .DEPTH(DEPTH)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_command(req_command),
      .req_position(req_position),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_count(rsp_count),
      .rsp_read_value(rsp_read_value)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Apply one accepted command to the model and return the response it must produce
   function automatic list_result_type list_apply(list_command_type cmd);
      list_result_type r;
      int              i;
      r.status     = ST_OK;
      r.read_value = '0;
      case (cmd.command)
         CMD_INSERT: begin
            if (model_count >= DEPTH) begin
               r.status = ST_FULL;
            end else if (cmd.position > model_count) begin
               r.status = ST_BADPOS;
            end else begin
               for (i = model_count; i > cmd.position; i--)
                  model_entries[i] = model_entries[i-1];
               model_entries[cmd.position] = cmd.value;
               model_count++;
            end
         end
         CMD_DELETE: begin
            if (model_count == 0) begin
               r.status = ST_EMPTY;
            end else if (cmd.position >= model_count) begin
               r.status = ST_BADPOS;
            end else begin
               for (i = cmd.position; i + 1 < model_count; i++)
                  model_entries[i] = model_entries[i+1];
               model_count--;
            end
         end
         CMD_READ: begin
            if (model_count == 0) begin
               r.status = ST_EMPTY;
            end else if (cmd.position >= model_count) begin
               r.status = ST_BADPOS;
            end else begin
               r.read_value = model_entries[cmd.position];
            end
         end
         default: r.status = ST_BADPOS;
      endcase
      if (model_count > peak_count)
         peak_count = model_count;
      r.count = model_count[COUNT_W-1:0];
      return r;
   endfunction

   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0:       return 32'sh7fff_ffff;
         1:       return 32'sh8000_0000;
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // Queue a transaction and track the count the generator expects, to steer the sequence
   task automatic queue_command(logic [1:0] cmd, int pos, logic signed [VALUE_W-1:0] val);
      list_command_type item;
      item.command  = cmd;
      item.position = pos[POSITION_W-1:0];
      item.value    = val;
      pending_commands.push_back(item);
      commands_queued++;
      if (cmd == CMD_INSERT && plan_count < DEPTH && pos <= plan_count)
         plan_count++;
      else if (cmd == CMD_DELETE && plan_count > 0 && pos < plan_count)
         plan_count--;
   endtask

   // Mostly legal positions in alternating fill and drain stretches, with some noise
   task automatic queue_random(int n);
      int          k;
      int          roll;
      logic [1:0]  cmd;
      int          pos;
      for (k = 0; k < n; k++) begin
         if (stretch_left == 0) begin
            fill_mode    = !fill_mode;
            stretch_left = $urandom_range(80, 200);
         end
         stretch_left--;
         if ($urandom_range(0, 99) < 10) begin
            queue_command(2'($urandom_range(0, 3)), int'($urandom_range(0, 127)),
                          pick_value());
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 75)
               cmd = fill_mode ? CMD_INSERT : CMD_DELETE;
            else if (roll < 88)
               cmd = CMD_READ;
            else
               cmd = fill_mode ? CMD_DELETE : CMD_INSERT;
            if (cmd == CMD_INSERT) begin
               case ($urandom_range(0, 5))
                  0:       pos = 0;
                  1:       pos = plan_count;
                  default: pos = $urandom_range(0, plan_count);
               endcase
            end else if (plan_count == 0) begin
               pos = 0;
            end else begin
               case ($urandom_range(0, 5))
                  0:       pos = 0;
                  1:       pos = plan_count - 1;
                  default: pos = $urandom_range(0, plan_count - 1);
               endcase
            end
            queue_command(cmd, pos, pick_value());
         end
      end
   endtask

   // Wait until every queued transaction has been answered and checked
   task automatic wait_drained();
      while (results_checked < commands_queued)
         @(posedge clock);
   endtask

   task automatic run_phase(int idle_pct, int stall_pct, bit with_hold);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      queue_random(PHASE_ITEMS);
      if (with_hold)
         pressure_go = 1'b1;
      wait_drained();
   endtask

   // Driver: offer the next pending transaction, predict on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_results.push_back(list_apply(offered_command));
            commands_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (pending_commands.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               offered_command = pending_commands.pop_front();
               req_valid    <= 1'b1;
               req_command  <= offered_command.command;
               req_position <= offered_command.position;
               req_value    <= offered_command.value;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each accepted response against the oldest prediction, then pick ready
   always @(posedge clock) begin : monitor
      list_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $error("unexpected response: status %0d count %0d read_value %0d",
                      rsp_status, rsp_count, rsp_read_value);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               results_checked++;
               status_seen[rsp_status]++;
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_status);
                  error_count++;
               end
               if (rsp_count !== want.count) begin
                  $error("count: expected %0d, actual %0d", want.count, rsp_count);
                  error_count++;
               end
               if (rsp_read_value !== want.read_value) begin
                  $error("read_value: expected %0d, actual %0d",
                         want.read_value, rsp_read_value);
                  error_count++;
               end
            end
         end
         rsp_ready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Hold off the response side for a long stretch so the block backs up into its input
   initial begin
      wait (pressure_go);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   // Abort a run that stops making progress
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty list, bad positions, extremes, append, middle insert and delete
      queue_command(CMD_READ, 0, '0);
      queue_command(CMD_DELETE, 0, '0);
      queue_command(CMD_DELETE, 127, '0);
      queue_command(CMD_INSERT, 1, 32'sh1234_5678);
      queue_command(CMD_INSERT, 0, 32'sh7fff_ffff);
      queue_command(CMD_INSERT, 0, 32'sh8000_0000);
      queue_command(CMD_INSERT, 2, '1);
      queue_command(CMD_INSERT, 1, '0);
      queue_command(CMD_READ, 0, '0);
      queue_command(CMD_READ, 1, '1);
      queue_command(CMD_READ, 2, '0);
      queue_command(CMD_READ, 3, '0);
      queue_command(CMD_READ, 4, '0);
      queue_command(CMD_READ, 127, '0);
      queue_command(CMD_INSERT, 5, 32'sh0bad_0bad);
      queue_command(CMD_INSERT, 127, '1);
      queue_command(CMD_DELETE, 4, '0);
      queue_command(CMD_DELETE, 1, '0);
      queue_command(CMD_READ, 1, '0);
      queue_command(CMD_UNUSED, 127, '1);
      queue_command(CMD_DELETE, 0, '0);
      queue_command(CMD_DELETE, 1, '0);
      queue_command(CMD_READ, 0, '0);
      queue_command(CMD_DELETE, 0, '0);
      queue_command(CMD_DELETE, 0, '0);
      wait_drained();

      // Random phases: free flow with a long response hold, then idling on each side
      run_phase(0, 0, 1'b1);
      run_phase(52, 0, 1'b0);
      run_phase(0, 52, 1'b0);
      run_phase(38, 38, 1'b0);

      repeat (10) @(posedge clock);
      $display("%0d transactions accepted, %0d responses checked, peak list length %0d",
               commands_accepted, results_checked, peak_count);
      $display("status ok %0d, full %0d, empty %0d, bad position %0d; %0d mismatches",
               status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
               status_seen[ST_BADPOS], error_count);
      if (error_count == 0 && expected_results.size() == 0 &&
          results_checked == commands_queued) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
